// File: rtl/core/bfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and constants of the best-fit block allocator: the beat
// formats of the request, response and internal command channels.
// ----------------------------------------------------------------------------
package bfba_pkg;

   // Number of block table entries
   localparam int TABLE_DEPTH = 64;

   // Fixed field widths of the external beats
   localparam int COUNT_W = 7;
   localparam int IDX_W   = 6;
   localparam int SIZE_W  = 32;

   // Table address width and width of a count that can hold TABLE_DEPTH itself
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SPAN_W = $clog2(TABLE_DEPTH + 1);

   // Command queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    load_index;
      logic [SIZE_W-1:0]   size_value;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [IDX_W-1:0]    chosen_index;
      logic [SIZE_W-1:0]   chosen_size;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
   } cmd_type;

   typedef struct packed {
      logic                full;
      logic                empty;
   } queue_status_type;

endpackage
`default_nettype wire

// File: rtl/core/bfba_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_front
// Request stage: registers each request beat, drops loads aimed beyond the
// table and passes the rest as commands to the queue.
// ----------------------------------------------------------------------------
module bfba_front
   import bfba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire req_type          req_payload,
   input  wire queue_status_type q_status,
   output      logic             push_valid,
   output      cmd_type          push_cmd
);

   logic    hold_valid_ff, hold_valid_in;
   logic    keep_ff, keep_in;
   cmd_type cmd_ff, cmd_in;
   logic    drain;
   logic    take;

   // A held command leaves when it is dropped or when the queue has room
   assign drain     = hold_valid_ff && (!keep_ff || !q_status.full);
   assign req_stall = hold_valid_ff && !drain;
   assign take      = req_valid && !req_stall;

   assign push_valid = hold_valid_ff && keep_ff && !q_status.full;
   assign push_cmd   = cmd_ff;

   always_comb begin
      hold_valid_in = take ? 1'b1 : (hold_valid_ff && !drain);
      keep_in       = (req_payload.op == OP_ALLOC) ||
                      (int'(req_payload.load_index) < TABLE_DEPTH);
      cmd_in.op     = req_payload.op;
      cmd_in.addr   = ADDR_W'(req_payload.load_index);
      cmd_in.size   = req_payload.size_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (take) begin
         keep_ff <= keep_in;
         cmd_ff  <= cmd_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/bfba_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_queue
// Short show-ahead command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module bfba_queue
   import bfba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire cmd_type          push_cmd,
   input  wire logic             pop,
   output      cmd_type          head_cmd,
   output      queue_status_type q_status
);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (int'(count_ff) == QUEUE_DEPTH);
   assign q_status.empty = (count_ff == '0);
   assign do_push  = push_valid && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(int'(wr_ptr_ff) + 1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(int'(rd_ptr_ff) + 1) : rd_ptr_ff;
      count_in  = QCNT_W'(int'(count_ff) + int'(do_push) - int'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/bfba_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_back
// Executes commands: loads write the size memory and free the entry,
// allocates scan the table one entry a cycle for the best fit.
// ----------------------------------------------------------------------------
module bfba_back
   import bfba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [COUNT_W-1:0]  block_count,
   input  wire cmd_type             head_cmd,
   input  wire queue_status_type    q_status,
   output      logic                pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      rsp_type             rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [SIZE_W-1:0]   size_mem [TABLE_DEPTH];
   logic [SIZE_W-1:0]   rd_size_ff;
   logic [TABLE_DEPTH-1:0] taken_ff;

   logic [SPAN_W-1:0]   span_ff;
   logic [SPAN_W-1:0]   ptr_ff;
   logic [SIZE_W-1:0]   want_ff;
   logic                cmp_valid_ff;
   logic                cmp_taken_ff;
   logic [ADDR_W-1:0]   cmp_addr_ff;
   logic                found_ff;
   logic [ADDR_W-1:0]   best_addr_ff;
   logic [SIZE_W-1:0]   best_size_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_payload_ff;

   logic                mem_we;
   logic [ADDR_W-1:0]   rd_addr;
   logic                issue;
   logic                fits;
   logic                better;
   logic                out_free;
   logic [SPAN_W-1:0]   span_in;

   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;
   assign mem_we   = pop && (head_cmd.op == OP_LOAD);
   assign rd_addr  = ptr_ff[ADDR_W-1:0];
   assign issue    = (state_ff == ST_SCAN) && (ptr_ff < span_ff);
   assign fits     = cmp_valid_ff && !cmp_taken_ff && (rd_size_ff >= want_ff);
   assign better   = fits && (!found_ff || (rd_size_ff < best_size_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign span_in  = (int'(block_count) > TABLE_DEPTH) ? SPAN_W'(TABLE_DEPTH)
                                                       : SPAN_W'(block_count);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Size memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[head_cmd.addr] <= head_cmd.size;
      end
      rd_size_ff <= size_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         taken_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise a new result beat, or drop one the receiver has taken
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         cmp_valid_ff <= issue;
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (head_cmd.op == OP_LOAD) begin
                     taken_ff[head_cmd.addr] <= 1'b0;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (!issue && !cmp_valid_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  if (found_ff) begin
                     taken_ff[best_addr_ff] <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      // Datapath registers
      if (pop) begin
         span_ff  <= span_in;
         want_ff  <= head_cmd.size;
         ptr_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         if (issue) begin
            ptr_ff <= SPAN_W'(int'(ptr_ff) + 1);
         end
         if (better) begin
            found_ff     <= 1'b1;
            best_addr_ff <= cmp_addr_ff;
            best_size_ff <= rd_size_ff;
         end
      end
      cmp_taken_ff <= taken_ff[rd_addr];
      cmp_addr_ff  <= rd_addr;
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_payload_ff.granted      <= found_ff;
         rsp_payload_ff.chosen_index <= found_ff ? IDX_W'(best_addr_ff) : '0;
         rsp_payload_ff.chosen_size  <= found_ff ? best_size_ff : '0;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/best_fit_block_allocator_core.sv
`default_nettype none
// A load takes effect when the back pops it from the queue and writes the
//   size memory; an allocate is answered once the back has scanned span
//   entries, span being block_count capped at the table depth.
// Throughput: one load a cycle while the queue has room; one allocate at a
//   time, its scan set by the single read port of the size memory.
// Reset: synchronous, active high; clears marks, block_count, queue and valids.
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core
// Best-fit allocator over a table of block sizes, with a decoupled front
// (request register and classification) and back (memory and scan engine).
// ----------------------------------------------------------------------------
module best_fit_block_allocator_core
   import bfba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire req_type             req_payload,
   // response channel
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      rsp_type             rsp_payload,
   // block_count register write port
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [COUNT_W-1:0]  csr_block_count
);

   logic [COUNT_W-1:0] block_count_ff;
   logic               push_valid;
   cmd_type            push_cmd;
   cmd_type            head_cmd;
   queue_status_type   q_status;
   logic               pop;

   // User changes register only while idle; not enforced, every write taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         block_count_ff <= csr_block_count;
      end
   end

   // Front: hold the request beat, drop out-of-table loads, push commands
   bfba_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   // Queue: lets the front keep taking loads while the back scans
   bfba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .q_status   (q_status)
   );

   // Back: execute loads and best-fit scans; result beat held in a register
   bfba_back u_back (
      .clock       (clock),
      .reset       (reset),
      .block_count (block_count_ff),
      .head_cmd    (head_cmd),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// File: rtl/core/bfba_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_checker
// Port-level checks of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module bfba_checker
   import bfba_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_payload
);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // A refused request reports zero index and size
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.granted |->
         rsp_payload.chosen_index == '0 && rsp_payload.chosen_size == '0)
      else $error("refused response carries non-zero fields");

   // Reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind best_fit_block_allocator_core bfba_checker u_bfba_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
